// File: sv/fastq_base_quality_pairer_defines.svh
// ----------------------------------------------------------------------------
// fastq_base_quality_pairer_defines
// Assertion macros shared by the FASTQ pairer modules.
// ----------------------------------------------------------------------------
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef FASTQ_BASE_QUALITY_PAIRER_DEFINES_SVH
`define FASTQ_BASE_QUALITY_PAIRER_DEFINES_SVH

// A condition that must hold at every clock edge.
`define FBQP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// An antecedent that forces a consequent at the same edge.
`define FBQP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/fbqp_pkg.sv
// ----------------------------------------------------------------------------
// fbqp_pkg
// Types and constants shared by the FASTQ base/quality pairer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbqp_pkg;

    localparam logic [7:0] CHAR_AT   = 8'h40;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_N    = 8'h4E;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_HEADER = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER_WAIT,
        PH_HEADER_SKIP,
        PH_SEQUENCE,
        PH_PLUS_SKIP,
        PH_QUALITY
    } t_phase;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_PAIR,
        CMD_SEP,
        CMD_FINAL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [1:0] err;
    } t_cmd;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [7:0] base_out;
        logic [7:0] qual_out;
        logic       is_separator;
        logic [1:0] error_code;
        logic       stream_done;
    } t_out;

endpackage

// File: sv/fbqp_front.sv
// ----------------------------------------------------------------------------
// fbqp_front
// Parser: tracks the record phase and, where a byte calls for one, turns it
// into a store, pair, separator or final command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fastq_base_quality_pairer_defines.svh"

module fbqp_front #(
    parameter int MAX_READ = 1024,
    parameter int AW       = $clog2(MAX_READ),
    parameter int LW       = $clog2(MAX_READ + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fbqp_pkg::t_in    i_in_data,
    input  logic             i_q_full,
    output logic             o_push,
    output fbqp_pkg::t_cmd   o_cmd,
    output logic [AW-1:0]    o_addr
);

    fbqp_pkg::t_phase r_phase, n_phase;
    logic             r_after_nl, n_after_nl;
    logic [LW-1:0]    r_len, n_len;
    logic [LW-1:0]    r_pos, n_pos;
    logic             r_halted, n_halted;

    logic             accept;
    logic             nl;
    logic [LW-1:0]    pos_inc;

    // Once halted, items are taken and dropped without touching the queue.
    assign o_in_ready = r_halted | ~i_q_full;
    assign accept     = i_in_valid & o_in_ready;
    assign nl         = (i_in_data.text_byte == fbqp_pkg::CHAR_NL);
    assign pos_inc    = r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fbqp_pkg::PH_HEADER_WAIT;
            r_after_nl <= 1'b1;
            r_len      <= '0;
            r_pos      <= '0;
            r_halted   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_after_nl <= n_after_nl;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_halted   <= n_halted;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_after_nl = r_after_nl;
        n_len      = r_len;
        n_pos      = r_pos;
        n_halted   = r_halted;
        o_push     = 1'b0;
        o_cmd.kind = fbqp_pkg::CMD_WRITE;
        o_cmd.data = i_in_data.text_byte;
        o_cmd.err  = fbqp_pkg::ERR_NONE;
        o_addr     = r_len[AW-1:0];

        if (accept && !r_halted) begin
            if (i_in_data.end_of_input) begin
                o_push     = 1'b1;
                o_cmd.kind = fbqp_pkg::CMD_FINAL;
                n_halted   = 1'b1;
                if (r_phase == fbqp_pkg::PH_HEADER_WAIT ||
                    (r_phase == fbqp_pkg::PH_PLUS_SKIP && r_len == '0)) begin
                    o_cmd.err = fbqp_pkg::ERR_NONE;
                end else begin
                    o_cmd.err = fbqp_pkg::ERR_TRUNCATED;
                end
            end else begin
                n_after_nl = nl;
                case (r_phase)
                    fbqp_pkg::PH_HEADER_WAIT: begin
                        if (!nl) begin
                            o_push = 1'b1;
                            if (i_in_data.text_byte == fbqp_pkg::CHAR_AT && r_after_nl) begin
                                n_phase    = fbqp_pkg::PH_HEADER_SKIP;
                                n_len      = '0;
                                n_pos      = '0;
                                o_cmd.kind = fbqp_pkg::CMD_SEP;
                            end else begin
                                o_cmd.kind = fbqp_pkg::CMD_FINAL;
                                o_cmd.err  = fbqp_pkg::ERR_NO_HEADER;
                                n_halted   = 1'b1;
                            end
                        end
                    end
                    fbqp_pkg::PH_HEADER_SKIP: begin
                        if (nl) begin
                            n_phase = fbqp_pkg::PH_SEQUENCE;
                        end
                    end
                    fbqp_pkg::PH_SEQUENCE: begin
                        if (!nl) begin
                            if (i_in_data.text_byte == fbqp_pkg::CHAR_PLUS && r_after_nl) begin
                                n_phase = fbqp_pkg::PH_PLUS_SKIP;
                            end else if (r_len >= LW'(MAX_READ)) begin
                                o_push     = 1'b1;
                                o_cmd.kind = fbqp_pkg::CMD_FINAL;
                                o_cmd.err  = fbqp_pkg::ERR_TOO_LONG;
                                n_halted   = 1'b1;
                            end else begin
                                o_push     = 1'b1;
                                o_cmd.kind = fbqp_pkg::CMD_WRITE;
                                n_len      = r_len + 1'b1;
                            end
                        end
                    end
                    fbqp_pkg::PH_PLUS_SKIP: begin
                        if (nl) begin
                            n_phase = (r_len == '0) ? fbqp_pkg::PH_HEADER_WAIT
                                                    : fbqp_pkg::PH_QUALITY;
                        end
                    end
                    fbqp_pkg::PH_QUALITY: begin
                        if (!nl) begin
                            o_push     = 1'b1;
                            o_cmd.kind = fbqp_pkg::CMD_PAIR;
                            o_addr     = r_pos[AW-1:0];
                            n_pos      = pos_inc;
                            if (pos_inc >= r_len) begin
                                n_phase = fbqp_pkg::PH_HEADER_WAIT;
                            end
                        end
                    end
                    default: begin
                        n_phase = fbqp_pkg::PH_HEADER_WAIT;
                    end
                endcase
            end
        end
    end

    `FBQP_ASSERT_ALWAYS(a_len_bound, r_len <= LW'(MAX_READ), "read length beyond store")
    `FBQP_ASSERT_IMPLY(a_pos_in_read, r_phase == fbqp_pkg::PH_QUALITY, r_pos < r_len,
        "quality position past stored bases")
    `FBQP_ASSERT_IMPLY(a_quiet_halt, r_halted, !o_push, "command issued after halt")

endmodule

// File: sv/fbqp_queue.sv
// ----------------------------------------------------------------------------
// fbqp_queue
// Short command queue between the parser and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fastq_base_quality_pairer_defines.svh"

module fbqp_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_head,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PW = fbqp_pkg::QPTR_W;
    localparam int CW = fbqp_pkg::QCNT_W;

    logic [W-1:0]  r_mem [fbqp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(fbqp_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `FBQP_ASSERT_IMPLY(a_no_overflow, i_push && o_full, i_pop, "push into full queue")
    `FBQP_ASSERT_IMPLY(a_no_underflow, i_pop, !o_empty, "pop from empty queue")

endmodule

// File: sv/fbqp_back.sv
// ----------------------------------------------------------------------------
// fbqp_back
// Executes queued commands: writes bases into the store, reads them back for
// pairing, and holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbqp_back #(
    parameter int MAX_READ = 1024,
    parameter int AW       = $clog2(MAX_READ)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  fbqp_pkg::t_cmd   i_head_cmd,
    input  logic [AW-1:0]    i_head_addr,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output fbqp_pkg::t_out   o_out_data
);

    logic [7:0]          r_store [MAX_READ];
    logic                r_valid;
    fbqp_pkg::t_cmd_kind r_kind;
    logic [7:0]          r_base;
    logic [7:0]          r_qual;
    logic [1:0]          r_err;

    logic head_is_write;
    logic slot_free;

    assign head_is_write = (i_head_cmd.kind == fbqp_pkg::CMD_WRITE);
    assign slot_free     = ~r_valid | i_out_ready;
    // Stores need no output slot, so they drain even while the output stalls.
    assign o_pop         = ~i_q_empty & (head_is_write | slot_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && !head_is_write) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (head_is_write) begin
                r_store[i_head_addr] <= i_head_cmd.data;
            end else begin
                r_kind <= i_head_cmd.kind;
                r_qual <= i_head_cmd.data;
                r_err  <= i_head_cmd.err;
                r_base <= r_store[i_head_addr];
            end
        end
    end

    assign o_out_valid = r_valid;

    always_comb begin
        o_out_data.base_out     = 8'h00;
        o_out_data.qual_out     = 8'h00;
        o_out_data.is_separator = 1'b0;
        o_out_data.error_code   = fbqp_pkg::ERR_NONE;
        o_out_data.stream_done  = 1'b0;
        case (r_kind)
            fbqp_pkg::CMD_PAIR: begin
                o_out_data.base_out = r_base;
                o_out_data.qual_out = r_qual;
            end
            fbqp_pkg::CMD_SEP: begin
                o_out_data.base_out     = fbqp_pkg::CHAR_N;
                o_out_data.is_separator = 1'b1;
            end
            fbqp_pkg::CMD_FINAL: begin
                o_out_data.error_code  = r_err;
                o_out_data.stream_done = 1'b1;
            end
            default: begin
                o_out_data.base_out = 8'h00;
            end
        endcase
    end

endmodule

// File: sv/fastq_base_quality_pairer.sv
// ----------------------------------------------------------------------------
// fastq_base_quality_pairer
// Pairs FASTQ bases with quality bytes, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle for as long as the output
// side keeps up. A result passes through the command queue behind the parser
// and then the output register, where the base store's registered read
// lands. The queue holds four commands, so a stalled output lets the parser
// run on until the queue fills; base stores drain even while the output is
// stalled. The store holds MAX_READ bases and needs no clearing after reset.
`timescale 1ns / 1ps

module fastq_base_quality_pairer #(
    parameter int MAX_READ = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fbqp_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output fbqp_pkg::t_out  o_out_data
);

    localparam int AW = $clog2(MAX_READ);
    localparam int LW = $clog2(MAX_READ + 1);
    localparam int CMDW = $bits(fbqp_pkg::t_cmd);
    localparam int QW = CMDW + AW;

    logic             push;
    fbqp_pkg::t_cmd   push_cmd;
    logic [AW-1:0]    push_addr;
    logic             q_full;
    logic             q_empty;
    logic             pop;
    logic [QW-1:0]    q_head;
    fbqp_pkg::t_cmd   head_cmd;
    logic [AW-1:0]    head_addr;

    fbqp_front #(
        .MAX_READ (MAX_READ),
        .AW       (AW),
        .LW       (LW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_addr     (push_addr)
    );

    fbqp_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_cmd, push_addr}),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign head_cmd  = fbqp_pkg::t_cmd'(q_head[QW-1:AW]);
    assign head_addr = q_head[AW-1:0];

    fbqp_back #(
        .MAX_READ (MAX_READ),
        .AW       (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head_cmd  (head_cmd),
        .i_head_addr (head_addr),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FASTQ base/quality pairer. A FASTQ byte stream
// of directed and random records is fed with bursty valid; an in-bench model
// of the parser predicts every separator, base/quality pair and final item,
// and the output side is checked field by field under a varying stall pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import fbqp_pkg::*;

    localparam int MAX_READ = 1024;

    typedef enum int {
        END_CLEAN,
        END_STRAY,
        END_CUT_HEADER,
        END_CUT_SEQ,
        END_CUT_PLUS,
        END_EMPTY_PLUS,
        END_CUT_QUAL,
        END_TOO_LONG
    } t_ending;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } t_stall;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // Byte stream waiting to be sent and pairs waiting to come out.
    t_in  stream_q[$];
    t_out pair_expect_q[$];
    int   mismatches = 0;

    // Parser model state.
    t_phase     pair_phase = PH_HEADER_WAIT;
    bit         at_line_start = 1'b1;
    logic [7:0] base_mem[MAX_READ];
    int         bases_stored = 0;
    int         quals_paired = 0;
    bit         stream_closed = 1'b0;

    // Sender burst control and receiver stall pattern.
    int         burst_left = 8;
    int         gap_left = 0;
    t_stall     stall_mode = RX_OPEN;
    int         mode_left = 0;
    logic [7:0] ready_pat = 8'hFF;

    fastq_base_quality_pairer #(
        .MAX_READ(MAX_READ)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always #10 clk = ~clk;

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (mismatches < 30) begin
            $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got,
                     want);
        end
        mismatches++;
    endtask

    task automatic expect_result(input logic [7:0] base, input logic [7:0] qual,
                                 input logic sep, input logic [1:0] err, input logic done);
        t_out r;
        r.base_out     = base;
        r.qual_out     = qual;
        r.is_separator = sep;
        r.error_code   = err;
        r.stream_done  = done;
        pair_expect_q = {pair_expect_q, r};
    endtask

    task automatic close_stream(input logic [1:0] err);
        stream_closed = 1'b1;
        expect_result(8'h00, 8'h00, 1'b0, err, 1'b1);
    endtask

    // Advances the parser model by one accepted item.
    task automatic advance_pairer(input t_in item);
        logic [7:0] ch;
        bit         starts_line;
        bit         is_nl;
        logic [7:0] base;
        ch          = item.text_byte;
        starts_line = at_line_start;
        is_nl       = (ch == CHAR_NL);
        if (stream_closed) begin
            // Everything after the final item is dropped.
        end else if (item.end_of_input) begin
            if (pair_phase == PH_HEADER_WAIT || (pair_phase == PH_PLUS_SKIP && bases_stored == 0))
                close_stream(ERR_NONE);
            else
                close_stream(ERR_TRUNCATED);
        end else begin
            at_line_start = is_nl;
            case (pair_phase)
                PH_HEADER_WAIT: begin
                    if (!is_nl) begin
                        if (ch == CHAR_AT && starts_line) begin
                            pair_phase   = PH_HEADER_SKIP;
                            bases_stored = 0;
                            quals_paired = 0;
                            expect_result(CHAR_N, 8'h00, 1'b1, ERR_NONE, 1'b0);
                        end else begin
                            close_stream(ERR_NO_HEADER);
                        end
                    end
                end
                PH_HEADER_SKIP: begin
                    if (is_nl) pair_phase = PH_SEQUENCE;
                end
                PH_SEQUENCE: begin
                    if (!is_nl) begin
                        if (ch == CHAR_PLUS && starts_line) begin
                            pair_phase = PH_PLUS_SKIP;
                        end else if (bases_stored >= MAX_READ) begin
                            close_stream(ERR_TOO_LONG);
                        end else begin
                            base_mem[bases_stored] = ch;
                            bases_stored++;
                        end
                    end
                end
                PH_PLUS_SKIP: begin
                    if (is_nl) pair_phase = (bases_stored == 0) ? PH_HEADER_WAIT : PH_QUALITY;
                end
                PH_QUALITY: begin
                    if (!is_nl) begin
                        base = base_mem[quals_paired];
                        quals_paired++;
                        if (quals_paired >= bases_stored) pair_phase = PH_HEADER_WAIT;
                        expect_result(base, ch, 1'b0, ERR_NONE, 1'b0);
                    end
                end
                default: begin
                    pair_phase = PH_HEADER_WAIT;
                end
            endcase
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (pair_expect_q.size() == 0) begin
            note_mismatch("item with nothing expected", 32'(got), 0);
        end else begin
            want = pair_expect_q.pop_front();
            if (got.base_out !== want.base_out)
                note_mismatch("base_out", 32'(got.base_out), 32'(want.base_out));
            if (got.qual_out !== want.qual_out)
                note_mismatch("qual_out", 32'(got.qual_out), 32'(want.qual_out));
            if (got.is_separator !== want.is_separator)
                note_mismatch("is_separator", 32'(got.is_separator),
                              32'(want.is_separator));
            if (got.error_code !== want.error_code)
                note_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
            if (got.stream_done !== want.stream_done)
                note_mismatch("stream_done", 32'(got.stream_done), 32'(want.stream_done));
        end
    endtask

    task automatic push_item(input logic [7:0] b, input logic eoi);
        t_in it;
        it.text_byte    = b;
        it.end_of_input = eoi;
        stream_q = {stream_q, it};
    endtask

    function automatic logic [7:0] rand_text();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHAR_NL) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic push_line(input int max_len);
        repeat ($urandom_range(0, max_len)) push_item(rand_text(), 1'b0);
        push_item(CHAR_NL, 1'b0);
    endtask

    // Sequence bytes over random line breaks; a '+' never opens a line here.
    task automatic push_bases(input int count);
        logic [7:0] b;
        int         col;
        col = 0;
        for (int i = 0; i < count; i++) begin
            if (col > 0 && $urandom_range(0, 15) == 0) begin
                push_item(CHAR_NL, 1'b0);
                if ($urandom_range(0, 3) == 0) push_item(CHAR_NL, 1'b0);
                col = 0;
            end
            b = rand_text();
            if (col == 0 && b == CHAR_PLUS) b = CHAR_N;
            push_item(b, 1'b0);
            col++;
        end
    endtask

    task automatic push_quals(input int count);
        for (int i = 0; i < count; i++) begin
            if (i > 0 && $urandom_range(0, 19) == 0) push_item(CHAR_NL, 1'b0);
            push_item(rand_text(), 1'b0);
        end
    endtask

    task automatic push_record(input int count, input bit close_line);
        push_item(CHAR_AT, 1'b0);
        push_line(10);
        push_bases(count);
        push_item(CHAR_NL, 1'b0);
        push_item(CHAR_PLUS, 1'b0);
        push_line(3);
        if (count > 0) begin
            push_quals(count);
            if (close_line) push_item(CHAR_NL, 1'b0);
        end
        if (close_line && $urandom_range(0, 3) == 0) push_item(CHAR_NL, 1'b0);
    endtask

    // Sender: bursts of items separated by idle gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) advance_pairer(in_data);
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0 || stream_q.size() == 0) begin
                    in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= stream_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: checks each accepted item and moves between stall modes.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) check_result(o_out_data);
            if (mode_left == 0) begin
                stall_mode = t_stall'($urandom_range(0, 2));
                mode_left  = $urandom_range(20, 80);
                ready_pat  = 8'($urandom_range(0, 255));
            end else begin
                mode_left--;
            end
            case (stall_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
                default: begin
                    out_ready <= ready_pat[0];
                    ready_pat = {ready_pat[0], ready_pat[7:1]};
                end
            endcase
        end
    end

    initial begin
        t_ending    ending;
        bit         big_wanted;
        bit         big_done;
        int         n;
        logic [7:0] b;

        // Blank line, record with extreme bases and a '+' inside the sequence,
        // '@' used as a quality byte, then a record with no bases.
        push_item(CHAR_NL, 1'b0);
        push_item(CHAR_AT, 1'b0);
        push_item(8'h68, 1'b0);
        push_item(CHAR_NL, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CHAR_PLUS, 1'b0);
        push_item(CHAR_NL, 1'b0);
        push_item(CHAR_PLUS, 1'b0);
        push_item(CHAR_NL, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CHAR_NL, 1'b0);
        push_item(CHAR_AT, 1'b0);
        push_item(CHAR_NL, 1'b0);
        push_item(CHAR_AT, 1'b0);
        push_item(CHAR_NL, 1'b0);
        push_item(CHAR_PLUS, 1'b0);
        push_item(CHAR_NL, 1'b0);

        // The stream can end only once per run, so the way it ends is drawn here.
        ending     = t_ending'($urandom_range(0, 7));
        big_wanted = (ending != END_TOO_LONG) && ($urandom_range(0, 2) == 0);
        big_done   = 1'b0;
        while (stream_q.size() < 550) begin
            if (big_wanted && !big_done && stream_q.size() > 150) begin
                n        = MAX_READ;
                big_done = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(0, 2);
            end else begin
                n = $urandom_range(3, 40);
            end
            push_record(n, 1'b1);
        end

        case (ending)
            END_CLEAN: begin
            end
            END_STRAY: begin
                if ($urandom_range(0, 1) == 0) begin
                    // '@' right after the last quality byte is not at a line start.
                    push_record($urandom_range(1, 6), 1'b0);
                    push_item(CHAR_AT, 1'b0);
                end else begin
                    b = rand_text();
                    if (b == CHAR_AT) b = CHAR_PLUS;
                    push_item(b, 1'b0);
                end
            end
            END_CUT_HEADER: begin
                push_item(CHAR_AT, 1'b0);
                repeat ($urandom_range(0, 5)) push_item(rand_text(), 1'b0);
            end
            END_CUT_SEQ: begin
                push_item(CHAR_AT, 1'b0);
                push_line(6);
                push_bases($urandom_range(0, 20));
            end
            END_CUT_PLUS: begin
                push_item(CHAR_AT, 1'b0);
                push_line(6);
                push_bases($urandom_range(1, 20));
                push_item(CHAR_NL, 1'b0);
                push_item(CHAR_PLUS, 1'b0);
                repeat ($urandom_range(0, 3)) push_item(rand_text(), 1'b0);
            end
            END_EMPTY_PLUS: begin
                push_item(CHAR_AT, 1'b0);
                push_line(6);
                push_item(CHAR_PLUS, 1'b0);
                repeat ($urandom_range(0, 3)) push_item(rand_text(), 1'b0);
            end
            END_CUT_QUAL: begin
                n = $urandom_range(2, 20);
                push_item(CHAR_AT, 1'b0);
                push_line(6);
                push_bases(n);
                push_item(CHAR_NL, 1'b0);
                push_item(CHAR_PLUS, 1'b0);
                push_line(3);
                push_quals($urandom_range(0, n - 1));
            end
            default: begin
                push_item(CHAR_AT, 1'b0);
                push_line(6);
                push_bases(MAX_READ + 1);
            end
        endcase
        push_item(8'($urandom_range(0, 255)), 1'b1);
        // The block is halted by now; these items must vanish without a trace.
        repeat ($urandom_range(2, 6))
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_q.size() != 0 || in_valid) @(posedge clk);
        while (pair_expect_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

// File: fastq_base_quality_pairer.f
+incdir+sv
sv/fbqp_pkg.sv
sv/fbqp_front.sv
sv/fbqp_queue.sv
sv/fbqp_back.sv
sv/fastq_base_quality_pairer.sv
tb/sv/tb.sv
